// File: sv/arh_pkg.sv
package arh_pkg;

  // Field widths of the channels.
  localparam int ACTION_W = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 3;
  localparam int VAR_W    = 64;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_WARMING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BINNED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABOVE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BELOW   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

  // Default range of -10..10 in Q16.16, used when the warmup is zero.
  localparam logic signed [DATA_W-1:0] DEF_RANGE_LO = -32'sd655360;
  localparam logic signed [DATA_W-1:0] DEF_RANGE_HI = 32'sd655360;

  localparam logic signed [DATA_W-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SMIN = 32'sh80000000;
  localparam logic [DATA_W-1:0]        UMAX = 32'hffffffff;

endpackage

// File: sv/arh_if.sv
// Input channel: one action with its operands.
interface arh_in_if import arh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [DATA_W-1:0]   sample;
  logic [INDEX_W-1:0]         bucket_index;

  modport source (output valid, action, sample, bucket_index, input ready);
  modport sink (input valid, action, sample, bucket_index, output ready);
endinterface

// Result channel: status and a snapshot of the statistics.
interface arh_out_if import arh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [INDEX_W-1:0]         bin_index;
  logic [DATA_W-1:0]          bin_count;
  logic [DATA_W-1:0]          sample_count;
  logic signed [DATA_W-1:0]   mean;
  logic [VAR_W-1:0]           variance;
  logic signed [DATA_W-1:0]   highest;
  logic signed [DATA_W-1:0]   lowest;
  logic [DATA_W-1:0]          above_count;
  logic [DATA_W-1:0]          below_count;
  logic signed [DATA_W-1:0]   range_low;
  logic signed [DATA_W-1:0]   range_high;

  modport source (output valid, status, bin_index, bin_count, sample_count, mean, variance,
                  highest, lowest, above_count, below_count, range_low, range_high,
                  input ready);
  modport sink (input valid, status, bin_index, bin_count, sample_count, mean, variance,
                highest, lowest, above_count, below_count, range_low, range_high,
                output ready);
endinterface

// Configuration channel: write data of the warmup register.
interface arh_cfg_if import arh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/arh_ram.sv
module arh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/auto_range_histogram_with_running_stats.sv
// Channel   | Modport | Transfer carries
// in_ch     | sink    | action, sample, bucket_index
// out_ch    | source  | status, bin data, count, mean, variance, extremes, counters, range
// cfg_ch    | sink    | warmup_samples write data (always ready)
//
// Between accepted input transfers, a binned put runs three
// 64-step passes of the shared restoring divider (bucket, mean and variance) and a
// 32-step shift-add multiply. A put that fixes the range runs a 32-step square root
// (skipped when the warmup is zero) in place of the bucket divide, and a divider pass for
// the bin width when NUM_BUCKETS is not a power of two. A read passes through S_RD1 and
// S_RD2; a clear sweeps every bucket to zero.
// After reset the bucket RAM is swept to zero with in_ch not ready.
// A finished result waits in the output register; a new item is taken meanwhile, and the
// sequencer holds its last state while that register is still full.
module auto_range_histogram_with_running_stats import arh_pkg::*; #(
  parameter int NUM_BUCKETS = 256
) (
  input  logic        clk,
  input  logic        rst,
  arh_in_if.sink      in_ch,
  arh_out_if.source   out_ch,
  arh_cfg_if.sink     cfg_ch
);

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int NB_SH = $clog2(NUM_BUCKETS);
  localparam bit NB_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_CLR      = 17'h00002,
    S_RD1      = 17'h00004,
    S_RD2      = 17'h00008,
    S_BIN_DIV  = 17'h00010,
    S_BIN_CHK  = 17'h00020,
    S_SQRT     = 17'h00040,
    S_RANGE    = 17'h00080,
    S_BW_DIV   = 17'h00100,
    S_STAT     = 17'h00200,
    S_MEAN_DIV = 17'h00400,
    S_MEAN_UPD = 17'h00800,
    S_MUL      = 17'h01000,
    S_M2       = 17'h02000,
    S_VAR      = 17'h04000,
    S_VAR_DIV  = 17'h08000,
    S_OUT      = 17'h10000
  } state_t;

  state_t state;

  // Statistics and configuration.
  logic [DATA_W-1:0]        warm;
  logic [DATA_W-1:0]        count;
  logic signed [DATA_W-1:0] mean;
  logic [VAR_W-1:0]         m2;
  logic [VAR_W-1:0]         var_q;
  logic signed [DATA_W-1:0] max_seen;
  logic signed [DATA_W-1:0] min_seen;
  logic [DATA_W-1:0]        over_cnt;
  logic [DATA_W-1:0]        under_cnt;
  logic signed [DATA_W-1:0] lo_b;
  logic signed [DATA_W-1:0] hi_b;
  logic [DATA_W-1:0]        bw;

  // Current item.
  logic signed [DATA_W-1:0] v;
  logic [STATUS_W-1:0]      status;
  logic [INDEX_W-1:0]       bidx;
  logic [DATA_W-1:0]        bcnt;
  logic                     is_bin;
  logic                     clr_out;
  logic signed [DATA_W:0]   dlt;
  logic                     d_in_neg_q;

  // Shared iterative units.
  logic [5:0]               step;
  logic [33:0]              dv_rem;
  logic [63:0]              dv_quo;
  logic [33:0]              dv_den;
  logic [63:0]              mu_acc;
  logic [63:0]              mu_a;
  logic [31:0]              mu_b;
  logic [63:0]              sq_x;
  logic [63:0]              sq_res;
  logic [63:0]              sq_bit;

  // Bucket memory.
  logic [IDX_W-1:0]         clr_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  logic [DATA_W-1:0]        bin_inc;

  arh_ram #(.WIDTH(DATA_W), .DEPTH(NUM_BUCKETS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign bin_inc   = (ram_rdata == UMAX) ? ram_rdata : ram_rdata + 32'd1;
  assign ram_we    = (state == S_CLR) || ((state == S_RD2) && is_bin);
  assign ram_waddr = (state == S_CLR) ? clr_idx : rd_addr;
  assign ram_wdata = (state == S_CLR) ? '0 : bin_inc;

  // Divider step: restoring, one quotient bit per cycle.
  logic [34:0] dv_sh;
  logic [34:0] dv_sub;
  logic        dv_ge;
  logic        div_busy;
  assign dv_sh    = {dv_rem, dv_quo[63]};
  assign dv_sub   = dv_sh - {1'b0, dv_den};
  assign dv_ge    = dv_sh >= {1'b0, dv_den};
  assign div_busy = (state == S_BIN_DIV) || (state == S_BW_DIV) ||
                    (state == S_MEAN_DIV) || (state == S_VAR_DIV);

  // Square root step.
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = sq_x >= sq_t;

  // Saturating count increment.
  logic [DATA_W-1:0] count_inc;
  assign count_inc = (count == UMAX) ? count : count + 32'd1;

  // Range from mean and three standard deviations, saturated; the default range when warmup is zero.
  logic [33:0]               sd3;
  logic signed [35:0]        m_ext;
  logic signed [35:0]        lo_raw;
  logic signed [35:0]        hi_raw;
  logic signed [DATA_W-1:0]  lo_new;
  logic signed [DATA_W-1:0]  hi_new;
  logic signed [DATA_W:0]    span;
  assign sd3    = {2'b00, sq_res[31:0]} + {1'b0, sq_res[31:0], 1'b0};
  assign m_ext  = (count == '0) ? '0 : 36'(mean);
  assign lo_raw = m_ext - $signed({2'b00, sd3});
  assign hi_raw = m_ext + $signed({2'b00, sd3});

  always_comb begin
    if (warm == '0) begin
      lo_new = DEF_RANGE_LO;
      hi_new = DEF_RANGE_HI;
    end else begin
      if (lo_raw > 36'(SMAX)) begin
        lo_new = SMAX;
      end else if (lo_raw < 36'(SMIN)) begin
        lo_new = SMIN;
      end else begin
        lo_new = lo_raw[DATA_W-1:0];
      end
      if (hi_raw > 36'(SMAX)) begin
        hi_new = SMAX;
      end else if (hi_raw < 36'(SMIN)) begin
        hi_new = SMIN;
      end else begin
        hi_new = hi_raw[DATA_W-1:0];
      end
    end
  end
  assign span = 33'(hi_new) - 33'(lo_new);

  // Offset of the incoming sample from the lower bound, and of the held sample from the mean.
  logic signed [DATA_W:0] d_in;
  logic [DATA_W:0]        a_in;
  logic signed [DATA_W:0] delta;
  logic [DATA_W-1:0]      dlt_mag;
  assign d_in    = 33'(in_ch.sample) - 33'(lo_b);
  assign a_in    = d_in[DATA_W] ? 33'(-d_in) : 33'(d_in);
  assign delta   = 33'(v) - 33'(mean);
  assign dlt_mag = dlt[DATA_W] ? 32'(-dlt) : 32'(dlt);

  // New mean and its distance to the sample.
  logic signed [33:0] q_s;
  logic signed [33:0] nm;
  logic signed [33:0] e;
  logic [31:0]        e_mag;
  assign q_s   = dlt[DATA_W] ? -$signed({1'b0, dv_quo[32:0]}) : $signed({1'b0, dv_quo[32:0]});
  assign nm    = 34'(mean) + q_s;
  assign e     = 34'(v) - nm;
  assign e_mag = e[33] ? 32'(-e) : 32'(e);

  // M2 accumulate, saturating.
  logic [64:0] m2_sum;
  assign m2_sum = {1'b0, m2} + {1'b0, mu_acc};

  // The result register takes a new result when it is empty or being emptied.
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_ch.valid || out_ch.ready);

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= '0;
    end else if (cfg_ch.valid) begin
      warm <= cfg_ch.data;
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_out   <= 1'b0;
      clr_idx   <= '0;
      count     <= '0;
      mean      <= '0;
      m2        <= '0;
      var_q     <= '0;
      max_seen  <= SMIN;
      min_seen  <= SMAX;
      over_cnt  <= '0;
      under_cnt <= '0;
      lo_b      <= '0;
      hi_b      <= '0;
      bw        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // Output valid: set on a hand-over, cleared after a transfer.
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end

      // Shared divider iteration.
      if (div_busy) begin
        dv_rem <= dv_ge ? dv_sub[33:0] : dv_sh[33:0];
        dv_quo <= {dv_quo[62:0], dv_ge};
        step   <= step + 6'd1;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            v    <= in_ch.sample;
            bcnt <= '0;
            case (in_ch.action)
              ACT_PUT: begin
                bidx <= '0;
                if (in_ch.sample > max_seen) begin
                  max_seen <= in_ch.sample;
                end
                if (in_ch.sample < min_seen) begin
                  min_seen <= in_ch.sample;
                end
                if (count < warm) begin
                  status <= ST_WARMING;
                  state  <= S_STAT;
                end else if (count == warm) begin
                  status <= ST_RANGE;
                  sq_x   <= var_q;
                  sq_res <= '0;
                  sq_bit <= 64'h4000_0000_0000_0000;
                  step   <= '0;
                  state  <= (warm == '0) ? S_RANGE : S_SQRT;
                end else if (bw == '0) begin
                  if (!d_in[DATA_W]) begin
                    status   <= ST_ABOVE;
                    over_cnt <= (over_cnt == UMAX) ? over_cnt : over_cnt + 32'd1;
                  end else begin
                    status    <= ST_BELOW;
                    under_cnt <= (under_cnt == UMAX) ? under_cnt : under_cnt + 32'd1;
                  end
                  state <= S_STAT;
                end else begin
                  // Rounded bucket: (2a + w) / (2w).
                  dv_quo <= 64'({a_in, 1'b0}) + 64'(bw);
                  dv_den <= {1'b0, bw, 1'b0};
                  dv_rem <= '0;
                  step   <= '0;
                  state  <= S_BIN_DIV;
                end
              end
              ACT_CLEAR: begin
                bidx      <= '0;
                status    <= ST_CLEARED;
                count     <= '0;
                mean      <= '0;
                m2        <= '0;
                var_q     <= '0;
                max_seen  <= SMIN;
                min_seen  <= SMAX;
                over_cnt  <= '0;
                under_cnt <= '0;
                clr_idx   <= '0;
                clr_out   <= 1'b1;
                state     <= S_CLR;
              end
              default: begin
                status <= ST_READ;
                bidx   <= in_ch.bucket_index;
                is_bin <= 1'b0;
                if (32'(in_ch.bucket_index) < 32'(NUM_BUCKETS)) begin
                  rd_addr <= IDX_W'(in_ch.bucket_index);
                  state   <= S_RD1;
                end else begin
                  state <= S_OUT;
                end
              end
            endcase
          end
        end

        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(NUM_BUCKETS - 1)) begin
            state <= clr_out ? S_OUT : S_IDLE;
          end
        end

        S_BIN_DIV: begin
          if (step == 6'd63) begin
            state <= S_BIN_CHK;
          end
        end

        S_BIN_CHK: begin
          if (d_in_neg_q && (dv_quo != '0)) begin
            status    <= ST_BELOW;
            under_cnt <= (under_cnt == UMAX) ? under_cnt : under_cnt + 32'd1;
            state     <= S_STAT;
          end else if (dv_quo >= 64'(NUM_BUCKETS)) begin
            status   <= ST_ABOVE;
            over_cnt <= (over_cnt == UMAX) ? over_cnt : over_cnt + 32'd1;
            state    <= S_STAT;
          end else begin
            status  <= ST_BINNED;
            rd_addr <= dv_quo[IDX_W-1:0];
            is_bin  <= 1'b1;
            state   <= S_RD1;
          end
        end

        S_RD1: begin
          state <= S_RD2;
        end

        S_RD2: begin
          if (is_bin) begin
            bidx  <= INDEX_W'(rd_addr);
            bcnt  <= bin_inc;
            state <= S_STAT;
          end else begin
            bcnt  <= ram_rdata;
            state <= S_OUT;
          end
        end

        S_SQRT: begin
          if (sq_ge) begin
            sq_x   <= sq_x - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          step   <= step + 6'd1;
          if (step == 6'd31) begin
            state <= S_RANGE;
          end
        end

        // A power-of-two bucket count turns the bin width into a shift.
        S_RANGE: begin
          lo_b <= lo_new;
          hi_b <= hi_new;
          if (span[DATA_W]) begin
            bw    <= '0;
            state <= S_STAT;
          end else if (NB_POW2) begin
            bw    <= span[DATA_W-1:0] >> NB_SH;
            state <= S_STAT;
          end else begin
            dv_quo <= 64'(span[DATA_W-1:0]);
            dv_den <= 34'(NUM_BUCKETS);
            dv_rem <= '0;
            step   <= '0;
            state  <= S_BW_DIV;
          end
        end

        S_BW_DIV: begin
          if (step == 6'd63) begin
            bw    <= {dv_quo[30:0], dv_ge};
            state <= S_STAT;
          end
        end

        S_STAT: begin
          if (count == '0) begin
            mean  <= v;
            m2    <= '0;
            count <= 32'd1;
            var_q <= '0;
            state <= S_OUT;
          end else begin
            dlt    <= delta;
            dv_quo <= 64'(delta[DATA_W] ? 33'(-delta) : 33'(delta));
            dv_den <= 34'(count_inc);
            dv_rem <= '0;
            step   <= '0;
            state  <= S_MEAN_DIV;
          end
        end

        S_MEAN_DIV: begin
          if (step == 6'd63) begin
            state <= S_MEAN_UPD;
          end
        end

        S_MEAN_UPD: begin
          mean   <= nm[DATA_W-1:0];
          mu_acc <= '0;
          mu_a   <= 64'(dlt_mag);
          mu_b   <= e_mag;
          step   <= '0;
          state  <= S_MUL;
        end

        S_MUL: begin
          if (mu_b[0]) begin
            mu_acc <= mu_acc + mu_a;
          end
          mu_a <= mu_a << 1;
          mu_b <= mu_b >> 1;
          step <= step + 6'd1;
          if (step == 6'd31) begin
            state <= S_M2;
          end
        end

        S_M2: begin
          m2    <= m2_sum[64] ? '1 : m2_sum[63:0];
          count <= count_inc;
          state <= S_VAR;
        end

        S_VAR: begin
          if (count < 32'd2) begin
            var_q <= '0;
            state <= S_OUT;
          end else begin
            dv_quo <= m2;
            dv_den <= 34'(count - 32'd1);
            dv_rem <= '0;
            step   <= '0;
            state  <= S_VAR_DIV;
          end
        end

        S_VAR_DIV: begin
          if (step == 6'd63) begin
            var_q <= {dv_quo[62:0], dv_ge};
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sign of the sample offset, kept for the bucket check after the divide.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_ch.valid) begin
      d_in_neg_q <= d_in[DATA_W];
    end
  end

  // Result register, loaded as the sequencer hands over.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status       <= status;
      out_ch.bin_index    <= bidx;
      out_ch.bin_count    <= bcnt;
      out_ch.sample_count <= count;
      out_ch.mean         <= (count == '0) ? '0 : mean;
      out_ch.variance     <= var_q;
      out_ch.highest      <= max_seen;
      out_ch.lowest       <= min_seen;
      out_ch.above_count  <= over_cnt;
      out_ch.below_count  <= under_cnt;
      out_ch.range_low    <= lo_b;
      out_ch.range_high   <= hi_b;
    end
  end

`ifndef SYNTHESIS
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.status == ST_CLEARED) |-> (out_ch.sample_count == '0))
    else $error("cleared result with nonzero sample count");

  a_var_small: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.sample_count < 32'd2) |-> (out_ch.variance == '0))
    else $error("variance nonzero with fewer than two samples");

  a_extremes: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.sample_count != '0) |-> (out_ch.lowest <= out_ch.highest))
    else $error("lowest above highest");

  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLR) || ((state == S_RD2) && (status == ST_BINNED))))
    else $error("bucket write outside sweep or binning");
`endif

endmodule
